// File: hw/rtl/fcb_pkg.sv
package fcb_pkg;

    localparam int CLUSTER_BYTES = 2048;
    localparam int MAP_CLUSTERS  = 1;
    localparam int STORE_DEPTH   = 2048;
    localparam int MAP_BYTES_RAW = CLUSTER_BYTES * MAP_CLUSTERS;
    localparam int MAP_BYTES     = (MAP_BYTES_RAW > STORE_DEPTH) ? STORE_DEPTH : MAP_BYTES_RAW;

    localparam int ADDR_W   = $clog2(STORE_DEPTH);
    localparam int BYTE_W   = 8;
    localparam int BITSEL_W = 3;
    localparam int CLUST_W  = 14;
    localparam int CMD_W    = 3;

    localparam logic [BYTE_W-1:0]   FULL_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0]   TOP_MASK  = 8'h80;
    localparam logic [ADDR_W-1:0]   LAST_ADDR = ADDR_W'(MAP_BYTES - 1);
    localparam logic [ADDR_W:0]     MAP_LIMIT = (ADDR_W + 1)'(MAP_BYTES);

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_USED  = 3'd0,
        CMD_SET_FREE  = 3'd1,
        CMD_READ_BIT  = 3'd2,
        CMD_FIND_FREE = 3'd3,
        CMD_CLEAR_ALL = 3'd4,
        CMD_LOAD_BYTE = 3'd5,
        CMD_READ_BYTE = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RMW,
        ST_FIND,
        ST_CLEAR,
        ST_DONE
    } state_t;

    // packed MSB first: is_dirty ends up in the top bit
    typedef struct packed {
        logic                is_dirty;
        logic [BYTE_W-1:0]   byte_out;
        logic                found;
        logic [CLUST_W-1:0]  free_index;
        logic                bit_value;
    } res_t;

    // offset of the first zero bit, bits numbered MSB first
    function automatic logic [BITSEL_W-1:0] first_zero(input logic [BYTE_W-1:0] b);
        logic [BITSEL_W-1:0] pos;
        pos = '0;
        for (int j = BYTE_W - 1; j >= 0; j--) begin
            if (!b[BYTE_W-1-j]) begin
                pos = BITSEL_W'(j);
            end
        end
        return pos;
    endfunction

endpackage

// File: hw/rtl/fcb_ram.sv
module fcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/free_cluster_bitmap_top.sv
// channel | dir | tdata (low bit up)                                    | tuser
// s_*     | in  | cluster_index[13:0], byte_index[24:14], byte_value[32:25] | cmd[2:0]
// m_*     | out | bit_value[0], free_index[14:1], found[15], byte_out[23:16],
//         |     | is_dirty[24]                                           | -
//
// Set used/free, read bit, read byte: RAM read, update, result stage.
// Load byte and unused code: accept (load writes the byte), then result stage. Find: reads from byte 0 on.
// Clear all: one byte written per cycle by the sequencer, then result stage.
// s_tready is high only when the sequencer is idle; a result stalled on m_tready
// holds the sequencer in its result stage. Map contents are undefined after reset.
module free_cluster_bitmap_top
    import fcb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // cluster_index, byte_index, byte_value
    input  logic [CMD_W-1:0]      s_tuser,   // cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // bit_value, free_index, found, byte_out, is_dirty
);

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [BITSEL_W-1:0]  bitsel_reg, bitsel_next;
    logic                 in_map_reg, in_map_next;
    logic                 dirty_reg, dirty_next;
    res_t                 res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    res_t                 m_data_reg, m_data_next;

    logic                 ram_we, ram_re;
    logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
    logic [BYTE_W-1:0]    ram_wdata, ram_rdata;

    logic [CLUST_W-1:0]   in_cluster;
    logic [ADDR_W-1:0]    in_byte_index;
    logic [BYTE_W-1:0]    in_byte_value;
    cmd_t                 in_cmd;
    logic [ADDR_W-1:0]    in_cb;
    logic [BYTE_W-1:0]    mask;
    logic                 out_free;

    assign in_cluster    = s_tdata[CLUST_W-1:0];
    assign in_byte_index = s_tdata[CLUST_W+ADDR_W-1:CLUST_W];
    assign in_byte_value = s_tdata[CLUST_W+ADDR_W+BYTE_W-1:CLUST_W+ADDR_W];
    assign in_cmd        = cmd_t'(s_tuser);
    assign in_cb         = in_cluster[CLUST_W-1:BITSEL_W];
    assign mask          = TOP_MASK >> bitsel_reg;
    assign out_free      = !m_valid_reg || m_tready;

    fcb_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(STORE_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            dirty_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            dirty_reg   <= dirty_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        addr_reg   <= addr_next;
        bitsel_reg <= bitsel_next;
        in_map_reg <= in_map_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        addr_next    = addr_reg;
        bitsel_next  = bitsel_reg;
        in_map_next  = in_map_reg;
        dirty_next   = dirty_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        s_tready     = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = addr_reg;
        ram_raddr    = addr_reg;
        ram_wdata    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd_next   = in_cmd;
                    res_next   = '0;
                    state_next = ST_DONE;
                    case (in_cmd)
                        CMD_SET_USED, CMD_SET_FREE, CMD_READ_BIT:
                        begin
                            ram_re      = 1'b1;
                            ram_raddr   = in_cb;
                            addr_next   = in_cb;
                            bitsel_next = in_cluster[BITSEL_W-1:0];
                            in_map_next = {1'b0, in_cb} < MAP_LIMIT;
                            state_next  = ST_RMW;
                        end
                        CMD_READ_BYTE:
                        begin
                            ram_re      = 1'b1;
                            ram_raddr   = in_byte_index;
                            addr_next   = in_byte_index;
                            in_map_next = {1'b0, in_byte_index} < MAP_LIMIT;
                            state_next  = ST_RMW;
                        end
                        CMD_FIND_FREE:
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = '0;
                            addr_next  = '0;
                            state_next = ST_FIND;
                        end
                        CMD_CLEAR_ALL:
                        begin
                            addr_next  = '0;
                            state_next = ST_CLEAR;
                        end
                        CMD_LOAD_BYTE:
                        begin
                            ram_we    = {1'b0, in_byte_index} < MAP_LIMIT;
                            ram_waddr = in_byte_index;
                            ram_wdata = in_byte_value;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_RMW:
            begin
                state_next = ST_DONE;
                case (cmd_reg)
                    CMD_SET_USED:
                    begin
                        ram_we     = in_map_reg;
                        ram_wdata  = ram_rdata | mask;
                        dirty_next = 1'b1;
                    end
                    CMD_SET_FREE:
                    begin
                        ram_we     = in_map_reg;
                        ram_wdata  = ram_rdata & ~mask;
                        dirty_next = 1'b1;
                    end
                    CMD_READ_BIT:
                    begin
                        res_next.bit_value = in_map_reg && |(ram_rdata & mask);
                    end
                    CMD_READ_BYTE:
                    begin
                        res_next.byte_out = in_map_reg ? ram_rdata : '0;
                        res_next.is_dirty = dirty_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // addr_reg names the byte now on ram_rdata
            ST_FIND:
            begin
                if (ram_rdata != FULL_BYTE)
                begin
                    res_next.free_index = {addr_reg, first_zero(ram_rdata)};
                    res_next.found      = 1'b1;
                    state_next          = ST_DONE;
                end
                else if (addr_reg == LAST_ADDR)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = addr_reg + 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
            end

            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                ram_wdata = '0;
                if (addr_reg == LAST_ADDR)
                begin
                    dirty_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - $bits(res_t))'(0), m_data_reg};

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in progress");

    a_dirty_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(dirty_reg))
        else $error("modified flag cleared");

    a_find_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIND |-> !ram_we)
        else $error("map written during scan");

    a_clear_writes_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> ram_we && ram_wdata == '0)
        else $error("clear pass skipped a byte");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_data_reg.found |-> m_data_reg.free_index == '0)
        else $error("free_index set without found");
`endif

endmodule
